@@ rtl/core/bmhq_pkg.sv @@
// Shared types, codes and defaults for the binary min-heap queue.
`default_nettype none
package bmhq_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 2 * DATA_W;
    localparam int OCC_W   = 6;
    localparam int STAT_W  = 2;
    localparam int OUT_W   = 72;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // One heap entry: priority in the upper half, value in the lower half.
    typedef struct packed {
        logic signed [DATA_W-1:0] pri;
        logic signed [DATA_W-1:0] val;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_START,
        ST_UP_CMP,
        ST_DN_LOAD,
        ST_DN_CMP,
        ST_DN_PUT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/core/bmhq_ram.sv @@
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none
module bmhq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

@@ rtl/core/binary_min_heap_queue.sv @@
// Top level of the binary min-heap priority queue.
// Each transaction on the input side either inserts a value with a signed
// priority or removes the entry of smallest priority, and yields exactly one
// result transaction carrying a status, the removed entry and the occupancy
// after the operation. The heap lives in a RAM with registered reads; insert
// sifts the new entry up and delete-min moves the last entry to the root and
// sifts it down, one heap level per cycle with the compare on the read data
// and the next level's read issued at once. The next input is taken as soon as
// the result is handed to the output register, even while that result still
// waits to be taken. Equal priorities never swap, so ties keep their order
// within the tree.
`default_nettype none
module binary_min_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // item_value [31:0], item_priority [63:32]
    input  wire logic [bmhq_pkg::ENTRY_W-1:0]  s_tdata,
    // op [0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // removed_value [31:0], removed_priority [63:32], occupancy [69:64], zero [71:70]
    output logic      [bmhq_pkg::OUT_W-1:0]    m_tdata,
    // status [1:0]
    output logic      [bmhq_pkg::STAT_W-1:0]   m_tuser
);

    import bmhq_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = CNT_W + 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    entry_t            key_reg, key_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] rv_reg, rv_next;
    logic [DATA_W-1:0] rp_reg, rp_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_rv_reg, m_rv_next;
    logic [DATA_W-1:0] m_rp_reg, m_rp_next;
    logic [OCC_W-1:0]  m_occ_reg, m_occ_next;

    logic          ram_we;
    logic [AW-1:0] ram_wr_addr;
    entry_t        ram_wr_data;
    logic [AW-1:0] ram_rd_addr_a, ram_rd_addr_b;
    entry_t        ram_rd_data_a, ram_rd_data_b;

    logic   in_accept;
    logic   heap_full;
    logic   heap_empty;
    logic   out_free;
    entry_t in_entry;

    logic [AW-1:0] pos_m1;
    logic [AW-1:0] up_par;
    logic [AW-1:0] up_par_m1;
    logic [AW-1:0] up_par_par;
    logic          up_less;

    logic [IW-1:0] count_ext;
    logic [IW-1:0] pos_ext;
    logic [IW-1:0] dn_child_l, dn_child_r;
    logic          dn_take_r;
    logic [IW-1:0] dn_idx;
    entry_t        dn_sel;
    logic          dn_move;
    logic [IW-1:0] dn_nxt_l, dn_nxt_r;

    logic [CNT_W+OCC_W-1:0] occ_wide;

    bmhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk       (clk),
        .wr_en     (ram_we),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (ram_rd_addr_a),
        .rd_data_a (ram_rd_data_a),
        .rd_addr_b (ram_rd_addr_b),
        .rd_data_b (ram_rd_data_b)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign heap_full  = (count_reg >= CNT_W'(CAPACITY));
    assign heap_empty = (count_reg == '0);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign in_entry   = s_tdata;

    // Sift-up addressing: parent of the current slot and of that parent.
    assign pos_m1     = pos_reg - 1'b1;
    assign up_par     = pos_m1 >> 1;
    assign up_par_m1  = up_par - 1'b1;
    assign up_par_par = up_par_m1 >> 1;
    assign up_less    = (key_reg.pri < ram_rd_data_a.pri);

    // Sift-down addressing; indices are widened so that 2*pos+2 cannot wrap.
    assign count_ext  = {1'b0, count_reg};
    assign pos_ext    = {{(IW-AW){1'b0}}, pos_reg};
    assign dn_child_l = {pos_ext[IW-2:0], 1'b1};
    assign dn_child_r = dn_child_l + 1'b1;
    assign dn_take_r  = (dn_child_r < count_ext) && (ram_rd_data_b.pri < ram_rd_data_a.pri);
    assign dn_idx     = dn_take_r ? dn_child_r : dn_child_l;
    assign dn_sel     = dn_take_r ? ram_rd_data_b : ram_rd_data_a;
    assign dn_move    = (dn_sel.pri < key_reg.pri);
    assign dn_nxt_l   = {dn_idx[IW-2:0], 1'b1};
    assign dn_nxt_r   = dn_nxt_l + 1'b1;

    assign occ_wide   = {{OCC_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == OP_INSERT)
                    begin
                        state_next = heap_full ? ST_DONE : ST_UP_START;
                    end
                    else
                    begin
                        state_next = heap_empty ? ST_DONE : ST_DN_LOAD;
                    end
                end
            end
            ST_UP_START:
            begin
                state_next = (pos_reg == '0) ? ST_DONE : ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                if (up_less)
                begin
                    state_next = (up_par == '0) ? ST_UP_START : ST_UP_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DN_LOAD:
            begin
                state_next = (count_reg == CNT_W'(1)) ? ST_DONE : ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (dn_move)
                begin
                    state_next = (dn_nxt_l < count_ext) ? ST_DN_CMP : ST_DN_PUT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DN_PUT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we        = 1'b0;
        ram_wr_addr   = pos_reg;
        ram_wr_data   = key_reg;
        ram_rd_addr_a = '0;
        ram_rd_addr_b = '0;
        count_next    = count_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        rv_next       = rv_reg;
        rp_next       = rp_reg;
        m_status_next = m_status_reg;
        m_rv_next     = m_rv_reg;
        m_rp_next     = m_rp_reg;
        m_occ_next    = m_occ_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == OP_INSERT)
                    begin
                        rv_next = '0;
                        rp_next = '0;
                        if (heap_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            status_next = STAT_OK;
                            key_next    = in_entry;
                            pos_next    = count_reg[AW-1:0];
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (heap_empty)
                        begin
                            status_next = STAT_EMPTY;
                            rv_next     = '1;
                            rp_next     = '1;
                        end
                        else
                        begin
                            // Fetch the root and the last entry together.
                            status_next   = STAT_OK;
                            ram_rd_addr_a = '0;
                            ram_rd_addr_b = AW'(count_reg - 1'b1);
                        end
                    end
                end
            end
            ST_UP_START:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_rd_addr_a = up_par;
                end
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (up_less)
                begin
                    // The parent moves down and the grandparent is fetched.
                    ram_wr_data   = ram_rd_data_a;
                    pos_next      = up_par;
                    ram_rd_addr_a = up_par_par;
                end
            end
            ST_DN_LOAD:
            begin
                rv_next       = ram_rd_data_a.val;
                rp_next       = ram_rd_data_a.pri;
                key_next      = ram_rd_data_b;
                count_next    = count_reg - 1'b1;
                pos_next      = '0;
                ram_rd_addr_a = AW'(1);
                ram_rd_addr_b = AW'(2);
            end
            ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (dn_move)
                begin
                    // The smaller child moves up and its own children are fetched.
                    ram_wr_data   = dn_sel;
                    pos_next      = dn_idx[AW-1:0];
                    ram_rd_addr_a = dn_nxt_l[AW-1:0];
                    ram_rd_addr_b = dn_nxt_r[AW-1:0];
                end
            end
            ST_DN_PUT:
            begin
                ram_we = 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_rv_next     = rv_reg;
                    m_rp_next     = rp_reg;
                    m_occ_next    = occ_wide[OCC_W-1:0];
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        rv_reg       <= rv_next;
        rp_reg       <= rp_next;
        m_status_reg <= m_status_next;
        m_rv_reg     <= m_rv_next;
        m_rp_reg     <= m_rp_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(OUT_W-OCC_W-ENTRY_W){1'b0}}, m_occ_reg, m_rp_reg, m_rv_reg};

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the binary min-heap queue: directed table, then random phases.
module tb;
    import bmhq_pkg::*;

    localparam int CAP            = CAPACITY_DEF;
    localparam int ITEMS          = 900;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int LIMIT_CYCLES   = 500000;
    localparam int N_DIRECTED     = 18;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [31:0]       value;
        logic [31:0]       prio;
        logic [OCC_W-1:0]  occ;
    } heap_result_t;

    typedef struct packed {
        logic         op;
        logic [31:0]  val;
        logic [31:0]  pri;
        logic         typed;
        heap_result_t want;
    } stim_row_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } op_mix_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [ENTRY_W-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // Predicted heap contents, kept in step with every accepted transaction.
    entry_t       heap_mem [CAP];
    int           heap_count;
    heap_result_t pending_results [$];

    int  mismatch_count;
    int  results_seen;
    int  items_sent;
    int  cycle_count;
    int  inserts_ok;
    int  inserts_refused;
    int  deletes_ok;
    int  deletes_empty;
    bit  quiet_phase;
    bit  holdoff_done;

    // Typed rows can be read straight off the heap behaviour; the rest use the predictor.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STAT_EMPTY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0}},
        '{OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{STAT_OK, 32'd0, 32'd0, 6'd1}},
        '{OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1, '{STAT_OK, 32'd0, 32'd0, 6'd2}},
        '{OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{STAT_OK, 32'd0, 32'd0, 6'd3}},
        '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{STAT_OK, 32'd0, 32'd0, 6'd4}},
        '{OP_INSERT, 32'hAAAA_AAAA, 32'h0000_0000, 1'b1, '{STAT_OK, 32'd0, 32'd0, 6'd5}},
        '{OP_INSERT, 32'h5555_5555, 32'h0000_0000, 1'b1, '{STAT_OK, 32'd0, 32'd0, 6'd6}},
        '{OP_INSERT, 32'h0000_0001, 32'h8000_0000, 1'b1, '{STAT_OK, 32'd0, 32'd0, 6'd7}},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STAT_OK, 32'h8000_0000, 32'h8000_0000, 6'd6}},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STAT_OK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0}},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STAT_EMPTY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0}},
        '{OP_INSERT, 32'h1234_5678, 32'hFFFF_FFFB, 1'b1, '{STAT_OK, 32'd0, 32'd0, 6'd1}},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STAT_OK, 32'h1234_5678, 32'hFFFF_FFFB, 6'd0}}
    };

    binary_min_heap_queue #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one operation to the predicted heap and returns the result it should give.
    function automatic heap_result_t heap_apply(logic op, logic signed [31:0] val,
                                                logic signed [31:0] pri);
        heap_result_t r;
        entry_t       moving;
        int           pos;
        int           up;
        int           child;
        r = '{STAT_OK, 32'd0, 32'd0, 6'd0};
        if (op == OP_INSERT)
        begin
            if (heap_count >= CAP)
                r.status = STAT_FULL;
            else
            begin
                moving.val = val;
                moving.pri = pri;
                pos = heap_count;
                heap_count++;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (moving.pri < heap_mem[up].pri)
                    begin
                        heap_mem[pos] = heap_mem[up];
                        pos = up;
                    end
                    else
                        break;
                end
                heap_mem[pos] = moving;
            end
        end
        else if (heap_count == 0)
        begin
            r.status = STAT_EMPTY;
            r.value  = 32'hFFFF_FFFF;
            r.prio   = 32'hFFFF_FFFF;
        end
        else
        begin
            r.value = heap_mem[0].val;
            r.prio  = heap_mem[0].pri;
            heap_count--;
            moving = heap_mem[heap_count];
            pos    = 0;
            child  = 1;
            // The right child wins only when strictly smaller, and a child rises only when
            // strictly below the moving entry, so equal priorities never trade places.
            while (child < heap_count)
            begin
                if (child + 1 < heap_count && heap_mem[child + 1].pri < heap_mem[child].pri)
                    child++;
                if (heap_mem[child].pri < moving.pri)
                begin
                    heap_mem[pos] = heap_mem[child];
                    pos   = child;
                    child = 2 * pos + 1;
                end
                else
                    break;
            end
            if (heap_count > 0)
                heap_mem[pos] = moving;
        end
        r.occ = OCC_W'(heap_count);
        return r;
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 60)
            return 0;
        if (roll < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic note_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR cycle %0d: %s expected %0h, got %0h",
                     cycle_count, what, want_v, got_v);
    endtask

    // Offers one transaction, waits for it to be taken and records what it should produce.
    task automatic send_item(logic op, logic [31:0] val, logic [31:0] pri,
                             logic typed, heap_result_t typed_want);
        int           gap;
        heap_result_t want;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pri, val};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = heap_apply(op, val, pri);
        if (typed)
            want = typed_want;
        pending_results.push_back(want);
        items_sent++;
        case (want.status)
            STAT_FULL:  inserts_refused++;
            STAT_EMPTY: deletes_empty++;
            default:
            begin
                if (op == OP_INSERT)
                    inserts_ok++;
                else
                    deletes_ok++;
            end
        endcase
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        heap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                note_mismatch("result with nothing pending", 64'd0, m_tdata[63:0]);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    note_mismatch("status", want.status, m_tuser);
                if (m_tdata[31:0] !== want.value)
                    note_mismatch("removed_value", want.value, m_tdata[31:0]);
                if (m_tdata[63:32] !== want.prio)
                    note_mismatch("removed_priority", want.prio, m_tdata[63:32]);
                if (m_tdata[69:64] !== want.occ)
                    note_mismatch("occupancy", want.occ, m_tdata[69:64]);
                if (m_tdata[71:70] !== 2'b00)
                    note_mismatch("padding bits", 64'd0, m_tdata[71:70]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("binary_min_heap_queue: mismatch");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so the queue stalls.
    initial
    begin : receiver
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && results_seen >= 250)
            begin
                holdoff_done = 1'b1;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLDOFF_CYCLES; k++)
                    @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                stall = idle_len();
                if (stall == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int       phase_len;
        int       insert_pct;
        bit       narrow;
        op_mix_t  mix;
        logic     op;
        logic [31:0] val;
        logic [31:0] pri;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_INSERT;
        heap_count     = 0;
        mismatch_count = 0;
        results_seen   = 0;
        items_sent     = 0;
        cycle_count    = 0;
        inserts_ok     = 0;
        inserts_refused = 0;
        deletes_ok     = 0;
        deletes_empty  = 0;
        quiet_phase    = 1'b0;
        holdoff_done   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].pri,
                      directed_rows[i].typed, directed_rows[i].want);

        // Phases lean to filling, draining or neither, so full and empty are hit often.
        while (items_sent < ITEMS)
        begin
            phase_len   = $urandom_range(20, 60);
            mix         = op_mix_t'($urandom_range(0, 2));
            narrow      = $urandom_range(0, 1);
            quiet_phase = ($urandom_range(0, 3) == 0);
            case (mix)
                MIX_FILL:  insert_pct = 85;
                MIX_DRAIN: insert_pct = 15;
                default:   insert_pct = 50;
            endcase
            for (int k = 0; k < phase_len; k++)
            begin
                op  = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
                val = $urandom;
                // A narrow key range makes ties common.
                pri = narrow ? $urandom_range(0, 8) - 4 : $urandom;
                send_item(op, val, pri, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        quiet_phase = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d transactions: %0d inserts, %0d refused as full, %0d deletes, %0d on empty.",
                 items_sent, inserts_ok, inserts_refused, deletes_ok, deletes_empty);
        $display("Checked %0d results with %0d mismatches.", results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("binary_min_heap_queue: match");
        else
            $display("binary_min_heap_queue: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ram.sv
rtl/core/binary_min_heap_queue.sv
tb/tb.sv
